// File: design/u8rd_pkg.sv
// Shared types, constants and helper functions for the utf-8 repair decoder.
// No dependencies; used by every module of the block.
package u8rd_pkg;

  localparam int unsigned MaxSeqBytesDef = 6;                   // default longest form
  localparam int unsigned MaxSeqBytesTop = 6;                   // upper end of the range
  localparam int unsigned HeldMax        = MaxSeqBytesTop - 1;  // held byte slots in a command
  localparam int unsigned CntW           = $clog2(MaxSeqBytesTop + 1);
  localparam int unsigned CpW            = 31;
  localparam int unsigned QDepth         = 2;

  localparam logic [CpW-1:0] ReplChar = CpW'(32'h0000_FFFD);

  typedef enum logic [1:0] {
    HowDecoded  = 2'd0,
    HowRaw      = 2'd1,
    HowReplaced = 2'd2
  } how_e;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_string;
  } in_t;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    how_e           how_made;
    logic           final_res;
  } out_t;

  // one step worth of work handed from front to back
  typedef struct packed {
    logic [CntW-1:0]          flush_cnt;  // held bytes given raw first
    logic [HeldMax-1:0][7:0]  held;
    logic                     mid_vld;    // one more result after the flush
    logic [CpW-1:0]           mid_cp;
    how_e                     mid_how;
    logic                     last;       // step carried end of string
  } cmd_t;

  // length of the form that a lead byte opens, zero if it is no multi-byte lead
  function automatic logic [CntW-1:0] lead_size(input logic [7:0] b);
    logic [CntW-1:0] s;
    s = '0;
    if (b[7:5] == 3'b110)         s = CntW'(2);
    else if (b[7:4] == 4'b1110)   s = CntW'(3);
    else if (b[7:3] == 5'b11110)  s = CntW'(4);
    else if (b[7:2] == 6'b111110) s = CntW'(5);
    else if (b[7:1] == 7'b1111110) s = CntW'(6);
    return s;
  endfunction

  // payload bits carried by a lead byte
  function automatic logic [4:0] lead_bits(input logic [7:0] b);
    logic [4:0] v;
    v = '0;
    if (b[7:5] == 3'b110)          v = b[4:0];
    else if (b[7:4] == 4'b1110)    v = {1'b0, b[3:0]};
    else if (b[7:3] == 5'b11110)   v = {2'b00, b[2:0]};
    else if (b[7:2] == 6'b111110)  v = {3'b000, b[1:0]};
    else                           v = {4'b0000, b[0]};
    return v;
  endfunction

endpackage

// File: design/utf8_repair_decoder.sv
// Top level of the utf-8 repair decoder: front, command queue, back.
// Depends on u8rd_pkg, u8rd_front, u8rd_queue and u8rd_back.
//
// usage
//   input side is a queue write port: a byte transfers at a clock edge with
//   push high and full low; end_of_string flags the last byte of a string
//   result side is a queue read port: the oldest result sits on out_data_o
//   while empty is low and transfers at an edge with pop high
// order and throughput
//   a byte that yields results shows its first one on out_data_o after the
//   command queue and the output register, and can transfer no earlier;
//   the front takes one byte per cycle while full is low, the back one
//   result per cycle while it has a command and room, so clean text streams
//   at one byte per cycle when nothing stalls; a step that gives n results
//   holds the back for all n; a broken sequence replays up to MAX_SEQ_BYTES
//   results from one byte; bytes that only extend an open sequence give none
// reset and stall
//   reset drops any open sequence, the command queue and the output register
//   a stalled receiver fills the output register, then the two-entry queue,
//   then full rises and holds off the sender; nothing is lost
module utf8_repair_decoder #(
  parameter int unsigned MAX_SEQ_BYTES = u8rd_pkg::MaxSeqBytesDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  u8rd_pkg::in_t  in_data_i,
  output logic           empty,
  input  logic           pop,
  output u8rd_pkg::out_t out_data_o
);
  import u8rd_pkg::*;

  // front to queue
  logic f_push;
  cmd_t f_cmd;
  logic acc;

  // queue to back
  logic q_vld;
  logic q_pop;
  cmd_t q_cmd;

  // byte transfer on the input side
  assign acc = push && !full;

  u8rd_front #(
    .MAX_SEQ_BYTES (MAX_SEQ_BYTES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .in_i      (in_data_i),
    .cmd_vld_o (f_push),
    .cmd_o     (f_cmd)
  );

  // full here is the only back pressure the sender sees
  u8rd_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (f_push),
    .wr_data_i (f_cmd),
    .full_o    (full),
    .rd_i      (q_pop),
    .vld_o     (q_vld),
    .rd_data_o (q_cmd)
  );

  // back drains the head command into the output register
  u8rd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_vld_i  (q_vld),
    .cmd_i      (q_cmd),
    .cmd_pop_o  (q_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_data_o (out_data_o)
  );

  // the last byte of a string always leaves work for the back part
  a_eos_makes_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && in_data_i.end_of_string) |-> f_push)
    else $error("end of string produced no command");

  // the head command only retires when the output register can take a result
  a_pop_needs_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> (empty || pop))
    else $error("command retired while output register blocked");

  // a full queue always has a head to work on
  a_full_has_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> q_vld)
    else $error("queue full without a valid head");

  // a result of the output register cannot vanish without a pop
  a_result_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result lost while stalled");

endmodule

// File: design/u8rd_front.sv
// Front part: takes bytes, tracks the open sequence and builds commands.
// Depends on u8rd_pkg.
module u8rd_front #(
  parameter int unsigned MAX_SEQ_BYTES = u8rd_pkg::MaxSeqBytesDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           acc_i,
  input  u8rd_pkg::in_t  in_i,
  output logic           cmd_vld_o,
  output u8rd_pkg::cmd_t cmd_o
);
  import u8rd_pkg::*;

  localparam int unsigned HeldDepth = MAX_SEQ_BYTES - 1;
  localparam int unsigned HIdxW     = $clog2(HeldDepth);

  logic [7:0]       held_q [HeldDepth];
  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  size_q, size_d;
  logic [CpW-1:0]   part_q, part_d;
  logic             held_we;
  logic [HIdxW-1:0] held_wa;

  logic [7:0]       b;
  logic             cont;
  logic [CntW-1:0]  lsize;
  logic             starts;
  logic [CpW-1:0]   newp;
  cmd_t             cmd;

  assign b      = in_i.byte_in;
  assign cont   = (b[7:6] == 2'b10);
  assign lsize  = lead_size(b);
  assign starts = (lsize != '0) && (lsize <= CntW'(MAX_SEQ_BYTES));
  assign newp   = {part_q[CpW-7:0], b[5:0]};

  always_comb begin
    cmd       = '0;
    cmd.last  = in_i.end_of_string;
    cmd.mid_how = HowRaw;
    for (int i = 0; i < HeldDepth; i++) begin
      cmd.held[i] = held_q[i];
    end
    count_d = count_q;
    size_d  = size_q;
    part_d  = part_q;
    held_we = 1'b0;
    held_wa = '0;
    if ((size_q != '0) && cont) begin
      if (({1'b0, count_q} + 1'b1) >= {1'b0, size_q}) begin
        cmd.mid_vld = 1'b1;
        cmd.mid_cp  = newp;
        cmd.mid_how = HowDecoded;
        count_d = '0;
        size_d  = '0;
        part_d  = '0;
      end else if (in_i.end_of_string) begin
        // string ends inside the sequence: everything held and this byte come out raw
        cmd.held[count_q] = b;
        cmd.flush_cnt     = count_q + 1'b1;
        count_d = '0;
        size_d  = '0;
        part_d  = '0;
      end else begin
        held_we = 1'b1;
        held_wa = count_q[HIdxW-1:0];
        count_d = count_q + 1'b1;
        part_d  = newp;
      end
    end else begin
      if (size_q != '0) begin
        // broken sequence, replay what was held
        cmd.flush_cnt = count_q;
        count_d = '0;
        size_d  = '0;
        part_d  = '0;
      end
      if ((b == 8'h00) || cont) begin
        cmd.mid_vld = 1'b1;
        cmd.mid_cp  = CpW'(b);
        cmd.mid_how = HowRaw;
      end else if (!b[7]) begin
        cmd.mid_vld = 1'b1;
        cmd.mid_cp  = CpW'(b);
        cmd.mid_how = HowDecoded;
      end else if (b[7:1] == 7'b1111111) begin
        cmd.mid_vld = 1'b1;
        cmd.mid_cp  = ReplChar;
        cmd.mid_how = HowReplaced;
      end else if (!starts || in_i.end_of_string) begin
        // lead too long, or lead opened and closed by the end of string
        cmd.mid_vld = 1'b1;
        cmd.mid_cp  = CpW'(b);
        cmd.mid_how = HowRaw;
      end else begin
        held_we = 1'b1;
        held_wa = '0;
        count_d = CntW'(1);
        size_d  = lsize;
        part_d  = CpW'(lead_bits(b));
      end
    end
  end

  assign cmd_o     = cmd;
  assign cmd_vld_o = acc_i && ((cmd.flush_cnt != '0) || cmd.mid_vld);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      size_q  <= '0;
      part_q  <= '0;
    end else if (acc_i) begin
      count_q <= count_d;
      size_q  <= size_d;
      part_q  <= part_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i && held_we) begin
      held_q[held_wa] <= b;
    end
  end

endmodule

// File: design/u8rd_queue.sv
// Short command queue between the front and back parts.
// Depends on u8rd_pkg.
module u8rd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  u8rd_pkg::cmd_t wr_data_i,
  output logic           full_o,
  input  logic           rd_i,
  output logic           vld_o,
  output u8rd_pkg::cmd_t rd_data_o
);
  import u8rd_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);

  cmd_t                  mem_q [QDepth];
  logic [PtrW-1:0]       wp_q, rp_q;
  logic [$clog2(QDepth+1)-1:0] cnt_q;

  assign full_o    = (cnt_q == ($clog2(QDepth+1))'(QDepth));
  assign vld_o     = (cnt_q != '0);
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i) begin
        wp_q <= (wp_q == PtrW'(QDepth - 1)) ? '0 : wp_q + 1'b1;
      end
      if (rd_i) begin
        rp_q <= (rp_q == PtrW'(QDepth - 1)) ? '0 : rp_q + 1'b1;
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

endmodule

// File: design/u8rd_back.sv
// Back part: walks one command a result at a time into the output register.
// Depends on u8rd_pkg.
module u8rd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_vld_i,
  input  u8rd_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           empty_o,
  input  logic           pop_i,
  output u8rd_pkg::out_t out_data_o
);
  import u8rd_pkg::*;

  logic [CntW-1:0] idx_q, idx_d;
  logic            ovld_q, ovld_d;
  out_t            out_q, out_d;
  logic            load;
  logic            in_flush;
  logic            cmd_end;

  assign load     = cmd_vld_i && (!ovld_q || pop_i);
  assign in_flush = (idx_q < cmd_i.flush_cnt);
  assign cmd_end  = in_flush ? ((idx_q + 1'b1 == cmd_i.flush_cnt) && !cmd_i.mid_vld)
                             : 1'b1;

  always_comb begin
    idx_d  = idx_q;
    ovld_d = ovld_q && !pop_i;
    out_d  = out_q;
    if (load) begin
      ovld_d = 1'b1;
      if (in_flush) begin
        out_d.code_point = CpW'(cmd_i.held[idx_q]);
        out_d.how_made   = HowRaw;
      end else begin
        out_d.code_point = cmd_i.mid_cp;
        out_d.how_made   = cmd_i.mid_how;
      end
      out_d.final_res = cmd_i.last && cmd_end;
      idx_d = cmd_end ? '0 : idx_q + 1'b1;
    end
  end

  assign cmd_pop_o  = load && cmd_end;
  assign empty_o    = !ovld_q;
  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      ovld_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

// File: verif/testbench.sv
// Self-checking testbench for utf8_repair_decoder: streams byte strings in, checks code points.
// Depends on u8rd_pkg and the utf8_repair_decoder design files; reads nothing else.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import u8rd_pkg::*;

  // longest form the instance accepts, kept in step with the default parameter
  localparam int unsigned LongestForm = MaxSeqBytesDef;
  localparam int unsigned HoldSlots   = 5;
  localparam int unsigned StepMax     = 6;
  localparam int unsigned RandomBytes = 156;

  // one queued byte, with a flag that makes the sender wait for a full drain first
  typedef struct packed {
    in_t  item;
    logic drain;
  } stim_t;

  logic clk_i      = 1'b0;
  logic rst_ni     = 1'b0;
  logic push       = 1'b0;
  logic pop        = 1'b0;
  in_t  in_data_i  = '0;
  logic full;
  logic empty;
  out_t out_data_o;

  stim_t byte_backlog[$];     // bytes still to be offered
  out_t  code_points_due[$];  // expected results, oldest first
  out_t  step_out[$];         // results of the byte being predicted

  // shadow of the decoder state
  logic [7:0]     seq_bytes[HoldSlots];
  int unsigned    seq_held = 0;
  int unsigned    seq_len  = 0;
  logic [CpW-1:0] seq_acc  = '0;

  int unsigned errors       = 0;
  int unsigned bytes_sent   = 0;
  int unsigned strings_sent = 0;
  int unsigned results_seen = 0;
  int unsigned full_stalls  = 0;
  int unsigned longest_step = 0;

  // sender and receiver pacing
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;
  int unsigned rx_cyc     = 0;
  int unsigned hold_left  = 0;
  bit          hold_done  = 1'b0;

  utf8_repair_decoder i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o)
  );

  // clock and the single reset at the start
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // one result of the current step; a step never gives more than StepMax
  task automatic emit(input logic [CpW-1:0] cp, input how_e how);
    out_t r;
    if (step_out.size() < StepMax) begin
      r.code_point = cp;
      r.how_made   = how;
      r.final_res  = 1'b0;
      step_out.push_back(r);
    end
  endtask

  // give up on the open sequence: lead and held continuations come out raw
  task automatic flush_seq();
    for (int unsigned i = 0; i < seq_held && i < HoldSlots; i++)
      emit(CpW'(seq_bytes[i]), HowRaw);
    seq_held = 0;
    seq_len  = 0;
    seq_acc  = '0;
  endtask

  // a byte seen with no sequence open
  task automatic open_byte(input logic [7:0] b);
    int unsigned    size;
    logic [CpW-1:0] bits;
    if (b == 8'h00 || (b >= 8'h80 && b < 8'hC0)) begin
      // nul and stray continuation bytes pass through raw
      emit(CpW'(b), HowRaw);
    end else if (b < 8'h80) begin
      emit(CpW'(b), HowDecoded);
    end else if (b >= 8'hFE) begin
      emit(ReplChar, HowReplaced);
    end else begin
      if (b < 8'hE0) begin
        size = 2; bits = CpW'(b & 8'h1F);
      end else if (b < 8'hF0) begin
        size = 3; bits = CpW'(b & 8'h0F);
      end else if (b < 8'hF8) begin
        size = 4; bits = CpW'(b & 8'h07);
      end else if (b < 8'hFC) begin
        size = 5; bits = CpW'(b & 8'h03);
      end else begin
        size = 6; bits = CpW'(b & 8'h01);
      end
      if (size > LongestForm) begin
        emit(CpW'(b), HowRaw);
      end else begin
        seq_bytes[0] = b;
        seq_held     = 1;
        seq_len      = size;
        seq_acc      = bits;
      end
    end
  endtask

  // works out what one accepted byte yields and queues it
  task automatic decode_byte(input in_t it);
    logic [7:0] b;
    out_t       r;
    b = it.byte_in;
    step_out.delete();
    if (seq_len != 0) begin
      if (b[7:6] == 2'b10) begin
        seq_acc = {seq_acc[CpW-7:0], b[5:0]};
        if (seq_held + 1 >= seq_len) begin
          emit(seq_acc, HowDecoded);
          seq_held = 0;
          seq_len  = 0;
          seq_acc  = '0;
        end else if (seq_held < HoldSlots) begin
          seq_bytes[seq_held] = b;
          seq_held++;
        end else begin
          flush_seq();
          emit(CpW'(b), HowRaw);
        end
      end else begin
        // broken sequence: replay, then decode the breaking byte afresh
        flush_seq();
        open_byte(b);
      end
    end else begin
      open_byte(b);
    end
    if (it.end_of_string) begin
      // string ends inside a sequence
      if (seq_len != 0) flush_seq();
      if (step_out.size() != 0) begin
        r = step_out.pop_back();
        r.final_res = 1'b1;
        step_out.push_back(r);
      end
    end
    if (step_out.size() > longest_step) longest_step = step_out.size();
    foreach (step_out[i]) code_points_due.push_back(step_out[i]);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------

  task automatic add_byte(input logic [7:0] b, input logic eos, input logic drain);
    stim_t s;
    s.item.byte_in       = b;
    s.item.end_of_string = eos;
    s.drain              = drain;
    byte_backlog.push_back(s);
  endtask

  // a lead byte for a form of sz bytes with random payload bits
  function automatic logic [7:0] lead_of(input int unsigned sz);
    logic [7:0] r;
    r = 8'($urandom_range(0, 255));
    case (sz)
      1:       r = {1'b0, r[6:0]};
      2:       r = {3'b110, r[4:0]};
      3:       r = {4'b1110, r[3:0]};
      4:       r = {5'b11110, r[2:0]};
      5:       r = {6'b111110, r[1:0]};
      default: r = {7'b1111110, r[0]};
    endcase
    return r;
  endfunction

  function automatic logic [7:0] cont_byte();
    logic [7:0] r;
    r = 8'($urandom_range(0, 255));
    return {2'b10, r[5:0]};
  endfunction

  // mostly well-formed sequences, some broken ones and some raw noise
  task automatic add_random_string(input logic drain);
    logic [7:0]  bytes[$];
    logic [7:0]  b;
    int unsigned sz;
    int unsigned k;
    repeat ($urandom_range(1, 4)) begin
      sz = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          bytes.push_back(lead_of(sz));
          repeat (sz - 1) bytes.push_back(cont_byte());
        end
        6, 7: begin
          if (sz < 2) sz = 2;
          bytes.push_back(lead_of(sz));
          k = $urandom_range(0, sz - 2);
          repeat (k) bytes.push_back(cont_byte());
          if ($urandom_range(0, 1) == 1) begin
            // something that is not a continuation breaks it
            do b = 8'($urandom_range(0, 255)); while (b[7:6] == 2'b10);
            bytes.push_back(b);
          end
        end
        default: begin
          repeat ($urandom_range(1, 3)) bytes.push_back(8'($urandom_range(0, 255)));
        end
      endcase
    end
    foreach (bytes[i])
      add_byte(bytes[i], (i == bytes.size() - 1), drain && (i == 0));
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers the backlog in bursts, predicts each transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    bit offer;
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        decode_byte(in_data_i);
        bytes_sent++;
        if (in_data_i.end_of_string) strings_sent++;
        void'(byte_backlog.pop_front());
        if (burst_left <= 1) begin
          // end of a burst; a quarter of the time no gap at all
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        end else begin
          burst_left--;
        end
      end else if (gap_left > 0) begin
        gap_left--;
      end
      if (push && full) full_stalls++;
      offer = 1'b0;
      if (gap_left == 0 && byte_backlog.size() != 0)
        // a drain-flagged byte waits until every expected result has come
        offer = !(byte_backlog[0].drain && code_points_due.size() != 0);
      push <= offer;
      if (offer) in_data_i <= byte_backlog[0].item;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: pops on a pattern of its own, checks each transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    bit   take;
    out_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        results_seen++;
        if (code_points_due.size() == 0) begin
          $error("unexpected result: code_point %h how_made %0d final_res %0b",
                 out_data_o.code_point, out_data_o.how_made, out_data_o.final_res);
          errors++;
        end else begin
          want = code_points_due.pop_front();
          if (want.code_point !== out_data_o.code_point) begin
            $error("code_point mismatch: expected %h, got %h",
                   want.code_point, out_data_o.code_point);
            errors++;
          end
          if (want.how_made !== out_data_o.how_made) begin
            $error("how_made mismatch: expected %0d, got %0d",
                   want.how_made, out_data_o.how_made);
            errors++;
          end
          if (want.final_res !== out_data_o.final_res) begin
            $error("final_res mismatch: expected %0b, got %0b",
                   want.final_res, out_data_o.final_res);
            errors++;
          end
        end
      end
      rx_cyc++;
      // one long hold-off so the block backs up and raises full
      if (!hold_done && results_seen >= 40) begin
        hold_left = 90;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else begin
        case ((rx_cyc / 50) % 4)
          0:       take = 1'b1;
          1:       take = $urandom_range(0, 1);
          2:       take = ($urandom_range(0, 4) != 0);
          default: take = ((rx_cyc % 5) < 2);
        endcase
      end
      pop <= take;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned settle;
    int unsigned planned;
    bit          mid_drain;

    mid_drain = 1'b0;

    // single bytes: nul, top ascii, stray continuations, both replacement leads
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'h7F, 1'b0, 1'b0);
    add_byte(8'h80, 1'b0, 1'b0);
    add_byte(8'hBF, 1'b0, 1'b0);
    add_byte(8'hFE, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b1, 1'b0);
    // longest form with every payload bit set gives the top code point
    add_byte(8'hFD, 1'b0, 1'b0);
    repeat (4) add_byte(8'hBF, 1'b0, 1'b0);
    add_byte(8'hBF, 1'b1, 1'b0);
    // broken three-byte form: lead raw, held byte raw, ascii decoded
    add_byte(8'hE2, 1'b0, 1'b0);
    add_byte(8'h82, 1'b0, 1'b0);
    add_byte(8'h41, 1'b1, 1'b0);
    // string ends inside a four-byte form
    add_byte(8'hF0, 1'b0, 1'b0);
    add_byte(8'h9F, 1'b0, 1'b0);
    add_byte(8'h98, 1'b1, 1'b0);
    // six-byte form broken after five bytes by a new lead that the end cuts off
    add_byte(8'hFC, 1'b0, 1'b0);
    repeat (4) add_byte(8'h80, 1'b0, 1'b0);
    add_byte(8'hF0, 1'b1, 1'b0);

    // random strings; the first one and one midway wait for a full drain
    planned = 0;
    while (planned < RandomBytes) begin
      settle = byte_backlog.size();
      add_random_string((planned == 0) || (!mid_drain && planned >= RandomBytes / 2));
      if (planned >= RandomBytes / 2) mid_drain = 1'b1;
      planned += byte_backlog.size() - settle;
    end

    @(posedge rst_ni);
    while (byte_backlog.size() != 0) @(posedge clk_i);
    settle = 0;
    while (code_points_due.size() != 0 && settle < 20000) begin
      @(posedge clk_i);
      settle++;
    end
    if (code_points_due.size() != 0) begin
      $error("%0d expected results never arrived", code_points_due.size());
      errors++;
    end
    // keep running to catch any stray extra result
    repeat (8) @(posedge clk_i);

    $display("run covered %0d bytes in %0d strings, %0d results checked, up to %0d per byte",
             bytes_sent, strings_sent, results_seen, longest_step);
    $display("sender was held off by full on %0d cycles", full_stalls);
    if (errors == 0) begin
      $display("** utf8_repair_decoder: PASSED **");
    end else begin
      $display("** utf8_repair_decoder: FAILED **");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("** utf8_repair_decoder: FAILED **");
    $finish;
  end

endmodule

// File: files.f
design/u8rd_pkg.sv
design/u8rd_front.sv
design/u8rd_queue.sv
design/u8rd_back.sv
design/utf8_repair_decoder.sv
verif/testbench.sv
